// ===== rtl/vwa_pkg.sv =====
`timescale 1ns / 1ps

package vwa_pkg;

  // Fixed field widths of the streams and the configuration register.
  localparam int COLUMN_W = 10;
  localparam int LEVEL_W  = 8;
  localparam int BIN_W    = 8;
  localparam int KIND_W   = 1;

  // tdata of the input stream: column and level, padded to whole bytes.
  localparam int IN_DATA_W  = ((COLUMN_W + LEVEL_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((BIN_W + 7) / 8) * 8;

  // One bin per level in every column.
  localparam int LEVELS = 256;

  localparam int COLUMNS_DEFAULT = 1024;

  localparam logic [BIN_W-1:0] BIN_MAX         = 8'd255;
  localparam logic [BIN_W-1:0] INTENSITY_RESET = 8'd10;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCUMULATE = 1'b0,
    KIND_READOUT    = 1'b1
  } kind_t;

endpackage

// ===== rtl/video_waveform_accumulator_top.sv =====
`timescale 1ns / 1ps

// Column-mode waveform monitor bin store. Each input transaction either adds the
// intensity register to the byte bin at (column, level), saturating at 255, or
// reads that bin out and clears it, giving one output transaction. The block takes
// one input transaction per clock: every item reads the bin store, which lives in
// a single dual-port RAM with a registered read, and writes the new value back in
// the following cycle; a readout then passes through the output queue to the
// output. Consecutive hits on the same bin are served by forwarding the last
// written value. A three-entry output queue keeps the input flowing while the
// downstream side stalls; the input only stops when that queue is close to full.
// After reset the RAM is cleared one bin per cycle, and s_axis_tready stays low
// until that pass is over, while configuration writes are accepted at any time.
module video_waveform_accumulator_top #(
  parameter int COLUMNS = vwa_pkg::COLUMNS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vwa_pkg::BIN_W-1:0]       cfg_data,      // intensity
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [vwa_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // column [9:0], level [17:10]
  input  logic [vwa_pkg::KIND_W-1:0]      s_axis_tuser,  // kind
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [vwa_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // bin_value
);

  import vwa_pkg::*;

  localparam int DEPTH      = COLUMNS * LEVELS;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FULL_W     = (ADDR_W > COLUMN_W + LEVEL_W) ? ADDR_W : COLUMN_W + LEVEL_W;
  localparam int FIFO_DEPTH = 3;

  logic [BIN_W-1:0]    intensity;

  logic                clr_active;
  logic [ADDR_W-1:0]   clr_addr;

  logic                in_accept;
  logic [COLUMN_W-1:0] in_column;
  logic [LEVEL_W-1:0]  in_level;
  logic [FULL_W-1:0]   in_full_addr;
  logic [ADDR_W-1:0]   in_addr;
  logic                in_ok;

  logic                s1_valid;
  kind_t               s1_kind;
  logic                s1_ok;
  logic [ADDR_W-1:0]   s1_addr;

  logic [BIN_W-1:0]    ram_rdata;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [BIN_W-1:0]    ram_wdata;

  logic                last_we;
  logic [ADDR_W-1:0]   last_addr;
  logic [BIN_W-1:0]    last_data;

  logic [BIN_W-1:0]    cur;
  logic [BIN_W:0]      sum;
  logic [BIN_W-1:0]    hit_value;
  logic                s1_we;
  logic [BIN_W-1:0]    s1_wdata;
  logic                s1_push;
  logic [BIN_W-1:0]    s1_result;

  logic [BIN_W-1:0]    fifo [FIFO_DEPTH];
  logic [1:0]          wr_ptr;
  logic [1:0]          rd_ptr;
  logic [1:0]          count;
  logic                pop;
  logic [2:0]          pending;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      intensity <= INTENSITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      intensity <= cfg_data;
    end
  end

  // Input decode.
  assign in_column    = s_axis_tdata[COLUMN_W-1:0];
  assign in_level     = s_axis_tdata[COLUMN_W+LEVEL_W-1:COLUMN_W];
  assign in_full_addr = FULL_W'({in_column, in_level});
  assign in_addr      = in_full_addr[ADDR_W-1:0];
  assign in_ok        = (32'(in_column) < 32'(COLUMNS));

  // Results in flight plus those queued must leave room for one more.
  assign pending       = {1'b0, count} + {2'b00, s1_push};
  assign s_axis_tready = !clr_active && (pending < 3'(FIFO_DEPTH));
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // Read stage: the RAM read is issued in the cycle of acceptance.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
    s1_kind <= kind_t'(s_axis_tuser);
    s1_ok   <= in_ok;
    s1_addr <= in_addr;
  end

  vwa_ram #(
    .WIDTH (BIN_W),
    .DEPTH (DEPTH)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // Modify stage. The RAM returns stale data when the previous item wrote the
  // same bin in the cycle of this read, so the last write is forwarded.
  assign cur       = (last_we && (last_addr == s1_addr)) ? last_data : ram_rdata;
  assign sum       = {1'b0, cur} + {1'b0, intensity};
  assign hit_value = sum[BIN_W] ? BIN_MAX : sum[BIN_W-1:0];

  assign s1_we     = s1_valid && s1_ok;
  assign s1_wdata  = (s1_kind == KIND_READOUT) ? '0 : hit_value;
  assign s1_push   = s1_valid && (s1_kind == KIND_READOUT);
  assign s1_result = s1_ok ? cur : '0;

  assign ram_we    = clr_active || s1_we;
  assign ram_waddr = clr_active ? clr_addr : s1_addr;
  assign ram_wdata = clr_active ? '0 : s1_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_we <= 1'b0;
    end else begin
      last_we <= s1_we;
    end
    last_addr <= s1_addr;
    last_data <= s1_wdata;
  end

  // Output queue.
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tdata  = OUT_DATA_W'(fifo[rd_ptr]);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s1_push) begin
        wr_ptr <= (wr_ptr == 2'(FIFO_DEPTH - 1)) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == 2'(FIFO_DEPTH - 1)) ? 2'd0 : rd_ptr + 2'd1;
      end
      if (s1_push && !pop) begin
        count <= count + 2'd1;
      end else if (!s1_push && pop) begin
        count <= count - 2'd1;
      end
    end
    if (s1_push) begin
      fifo[wr_ptr] <= s1_result;
    end
  end

  // The queue is never written while full unless an entry is also popped.
  assert property (@(posedge clk) disable iff (rst)
    !(s1_push && !pop && (count == 2'(FIFO_DEPTH))))
    else $error("output queue overflow");

  // A readout straight after a readout of the same bin must see the cleared bin.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_kind == KIND_READOUT) && s1_ok &&
     $past(s1_valid && (s1_kind == KIND_READOUT) && s1_ok) &&
     (s1_addr == $past(s1_addr))) |-> (cur == '0))
    else $error("forwarding missed a cleared bin");

  // An accumulate never lowers a bin.
  assert property (@(posedge clk) disable iff (rst)
    (s1_we && (s1_kind == KIND_ACCUMULATE)) |-> (s1_wdata >= cur))
    else $error("accumulate lowered a bin");

  // The clearing pass ends only after the last bin has been written.
  assert property (@(posedge clk) disable iff (rst)
    $fell(clr_active) |-> ($past(clr_addr) == ADDR_W'(DEPTH - 1)))
    else $error("clearing pass ended early");

endmodule

// ===== rtl/vwa_ram.sv =====
`timescale 1ns / 1ps

module vwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
